[hdl/lts_pkg.sv]
`default_nettype none

package lts_pkg;

   localparam int MaxTokenLength = 255;
   localparam int FifoDepth      = 4;

   typedef enum logic [2:0] {
      KIND_NUMBER = 3'd0,
      KIND_IDENT  = 3'd1,
      KIND_IF     = 3'd2,
      KIND_FOR    = 3'd3,
      KIND_WHILE  = 3'd4,
      KIND_PRINT  = 3'd5,
      KIND_CHAR   = 3'd6,
      KIND_END    = 3'd7
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_START  = 3'b001,
      MODE_NUMBER = 3'b010,
      MODE_IDENT  = 3'b100
   } scan_mode_type;

   typedef struct packed {
      logic           last;
      logic [63:0]    text;
      logic [7:0]     length;
      token_kind_type kind;
   } token_type;

   // keyword spellings, first byte in the lowest byte
   localparam logic [63:0] KwIfText    = 64'h0000_0000_0000_6669;
   localparam logic [63:0] KwForText   = 64'h0000_0000_0072_6f66;
   localparam logic [63:0] KwWhileText = 64'h0000_0065_6c69_6877;
   localparam logic [63:0] KwPrintText = 64'h0000_0074_6e69_7270;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h5f};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0d]};
   endfunction

   // kind of a finished identifier run: keyword only on exact length and bytes
   function automatic token_kind_type ident_kind(input logic [7:0] len,
                                                 input logic [63:0] text);
      token_kind_type kind;
      kind = KIND_IDENT;
      if (len == 8'd2 && text == KwIfText) kind = KIND_IF;
      if (len == 8'd3 && text == KwForText) kind = KIND_FOR;
      if (len == 8'd5 && text == KwWhileText) kind = KIND_WHILE;
      if (len == 8'd5 && text == KwPrintText) kind = KIND_PRINT;
      return kind;
   endfunction

endpackage

`default_nettype wire

[hdl/lexical_token_scanner_top.sv]
`default_nettype none

// Byte-serial lexical scanner.
// req channel: one source byte per request in req_tdata, or an end-of-input
//   mark on req_tuser. Whitespace is dropped; digit runs become number tokens,
//   letter/underscore runs become identifier or keyword (if, for, while, print)
//   tokens; any other byte is a one-byte token; end of input gives an end token.
// rsp channel: up to two tokens per request; rsp_tlast marks the last token caused
//   by a request. A byte that ends an open run yields the run's token and, if it is
//   a plain char or end of input, its own token. Tokens are written into the queue
//   when their request is taken. Throughput: one request per cycle while each gives
//   at most one token and rsp_tready stays high; a two-token request costs an extra
//   transfer. The rate is set by the single rsp port draining a four-entry queue.
// The queue decouples the sides: req_tready depends only on queue fill (at
//   least two free slots), so requests keep flowing while a token waits.
// When the receiver stalls, tokens pile up in the queue and req_tready drops
//   once fewer than two slots are free; nothing is lost.
// Reset (synchronous, active high) empties the queue and returns the scanner
// to start mode with an empty run.
module lexical_token_scanner_top #(
   parameter int MAX_TOKEN_LENGTH = lts_pkg::MaxTokenLength
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic        req_tuser,   // [0] end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [2:0] token_kind, [10:3] token_length,
                                         // [74:11] text_head, [79:75] zero
   output logic             rsp_tlast    // last_of_run
);

   localparam int SatLimit = (MAX_TOKEN_LENGTH > 255) ? 255 : MAX_TOKEN_LENGTH;
   localparam int PtrWidth = $clog2(lts_pkg::FifoDepth);
   localparam int CntWidth = $clog2(lts_pkg::FifoDepth + 1);

   // scanner state
   lts_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]             run_len_ff, run_len_in;
   logic [63:0]            head_ff, head_in;

   // token queue
   lts_pkg::token_type     fifo_ff [lts_pkg::FifoDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]    count_ff;

   logic                   req_fire, rsp_fire;
   logic [7:0]             ch;
   logic                   eoi;
   logic                   run_open, run_goes_on, flush, has_start;
   logic [8:0]             len_inc;
   lts_pkg::token_type     flush_tok, start_tok, tok_a, tok_b;
   logic [1:0]             push_n;

   assign req_tready = count_ff <= CntWidth'(lts_pkg::FifoDepth - 2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign ch         = req_tdata;
   assign eoi        = req_tuser;
   assign len_inc    = {1'b0, run_len_ff} + 9'd1;

   always_comb begin
      run_open    = 1'b0;
      run_goes_on = 1'b0;
      case (mode_ff)
         lts_pkg::MODE_NUMBER: begin
            run_open    = 1'b1;
            run_goes_on = !eoi && lts_pkg::is_digit(ch);
         end
         lts_pkg::MODE_IDENT: begin
            run_open    = 1'b1;
            run_goes_on = !eoi && (lts_pkg::is_alpha(ch) || lts_pkg::is_digit(ch));
         end
         default: begin
            run_open    = 1'b0;
            run_goes_on = 1'b0;
         end
      endcase
   end

   // token for a run that the current request closes
   always_comb begin
      flush_tok        = '0;
      flush_tok.length = run_len_ff;
      flush_tok.text   = head_ff;
      flush_tok.kind   = (mode_ff == lts_pkg::MODE_NUMBER) ? lts_pkg::KIND_NUMBER
                         : lts_pkg::ident_kind(run_len_ff, head_ff);
   end

   always_comb begin
      mode_in    = mode_ff;
      run_len_in = run_len_ff;
      head_in    = head_ff;
      flush      = 1'b0;
      has_start  = 1'b0;
      start_tok  = '0;
      if (req_fire) begin
         if (run_open && run_goes_on) begin
            // extend the run: keep the first eight bytes, saturate the length
            if (run_len_ff < 8'd8) begin
               head_in = head_ff | ({56'd0, ch} << {run_len_ff[2:0], 3'b000});
            end
            run_len_in = (len_inc > 9'(SatLimit)) ? 8'(SatLimit) : len_inc[7:0];
         end else begin
            flush      = run_open;
            mode_in    = lts_pkg::MODE_START;
            run_len_in = '0;
            head_in    = '0;
            // rescan this byte from start mode
            if (eoi) begin
               has_start      = 1'b1;
               start_tok.kind = lts_pkg::KIND_END;
            end else if (lts_pkg::is_digit(ch)) begin
               mode_in    = lts_pkg::MODE_NUMBER;
               run_len_in = 8'd1;
               head_in    = {56'd0, ch};
            end else if (lts_pkg::is_alpha(ch)) begin
               mode_in    = lts_pkg::MODE_IDENT;
               run_len_in = 8'd1;
               head_in    = {56'd0, ch};
            end else if (!lts_pkg::is_space(ch)) begin
               has_start        = 1'b1;
               start_tok.kind   = lts_pkg::KIND_CHAR;
               start_tok.length = 8'd1;
               start_tok.text   = {56'd0, ch};
            end
         end
      end
   end

   // order the tokens of this request and mark the last one
   always_comb begin
      tok_a = '0;
      tok_b = '0;
      if (flush) begin
         tok_a      = flush_tok;
         tok_a.last = !has_start;
         tok_b      = start_tok;
         tok_b.last = 1'b1;
         push_n     = has_start ? 2'd2 : 2'd1;
      end else begin
         tok_a      = start_tok;
         tok_a.last = 1'b1;
         push_n     = {1'b0, has_start};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lts_pkg::MODE_START;
         run_len_ff <= '0;
         head_ff    <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         mode_ff    <= mode_in;
         run_len_ff <= run_len_in;
         head_ff    <= head_in;
         wr_ptr_ff  <= wr_ptr_ff + PtrWidth'(push_n);
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         end
         count_ff   <= count_ff + CntWidth'(push_n) - CntWidth'(rsp_fire);
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= tok_a;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PtrWidth'(1)] <= tok_b;
      end
   end

   assign rsp_tdata = {5'd0, fifo_ff[rd_ptr_ff].text, fifo_ff[rd_ptr_ff].length,
                       fifo_ff[rd_ptr_ff].kind};
   assign rsp_tlast = fifo_ff[rd_ptr_ff].last;

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(lts_pkg::FifoDepth))
      else $error("token queue overflow");

   // start mode always holds an empty run
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == lts_pkg::MODE_START |-> run_len_ff == '0 && head_ff == '0)
      else $error("stale run in start mode");

   // end of input closes everything
   a_eoi_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && eoi |=> mode_ff == lts_pkg::MODE_START)
      else $error("scanner not in start mode after end of input");

   // an open run always holds at least one byte
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      mode_ff != lts_pkg::MODE_START |-> run_len_ff != '0)
      else $error("open run with zero length");

endmodule

`default_nettype wire

[tb/sv/lexical_token_scanner_top_tb.sv]
`timescale 1ns / 1ps

module lexical_token_scanner_top_tb;

   // scanner modes of the predictor
   localparam logic [1:0] LEX_START  = 2'd0;
   localparam logic [1:0] LEX_NUMBER = 2'd1;
   localparam logic [1:0] LEX_IDENT  = 2'd2;

   // run length never exceeds the parameter, nor the 8-bit field
   localparam int LENGTH_CAP = (lts_pkg::MaxTokenLength > 255) ? 255
                                                               : lts_pkg::MaxTokenLength;

   // keyword spellings, first byte in the lowest byte
   localparam logic [63:0] TEXT_IF    = 64'h6669;
   localparam logic [63:0] TEXT_FOR   = 64'h72_6f66;
   localparam logic [63:0] TEXT_WHILE = 64'h65_6c69_6877;
   localparam logic [63:0] TEXT_PRINT = 64'h74_6e69_7270;

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      logic       drain_first;   // hold this request until no token is owed
   } source_item_type;

   typedef struct {
      lts_pkg::token_kind_type kind;
      logic [7:0]              length;
      logic [63:0]             text;
      logic                    last;
   } scanned_token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] ch
   logic        req_tuser = 1'b0;    // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // [2:0] token_kind, [10:3] token_length,
                                     // [74:11] text_head, [79:75] zero
   logic        rsp_tlast;           // last_of_run

   source_item_type   source_items[$];
   scanned_token_type expected_tokens[$];

   // predictor state
   logic [1:0]  lex_mode = LEX_START;
   logic [7:0]  run_len = 8'd0;
   logic [63:0] run_head = 64'd0;

   int   items_pushed = 0;
   int   items_accepted = 0;
   int   error_count = 0;
   logic req_fired = 1'b0;   // set at the edge that takes a request
   logic hold_next = 1'b0;
   logic calm;
   source_item_type next_item;

   string keywords[4] = '{"if", "for", "while", "print"};
   string near_misses[15] = '{"i", "fo", "whil", "prin", "iff", "fork", "whiles",
                              "printf", "If", "FOR", "While", "pRint", "_if",
                              "for_", "x_print"};

   lexical_token_scanner_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // keyword only on exact length and bytes
   function automatic lts_pkg::token_kind_type ident_or_keyword(input logic [7:0] len,
                                                                input logic [63:0] head);
      if (len == 8'd2 && head == TEXT_IF) return lts_pkg::KIND_IF;
      if (len == 8'd3 && head == TEXT_FOR) return lts_pkg::KIND_FOR;
      if (len == 8'd5 && head == TEXT_WHILE) return lts_pkg::KIND_WHILE;
      if (len == 8'd5 && head == TEXT_PRINT) return lts_pkg::KIND_PRINT;
      return lts_pkg::KIND_IDENT;
   endfunction

   // keep the first eight bytes, saturate the count, keep scanning
   task automatic append_run(input logic [7:0] c);
      if (run_len < 8'd8) run_head[8*run_len +: 8] = c;
      if (run_len < LENGTH_CAP) run_len = run_len + 8'd1;
   endtask

   // advance the scanner by one request and queue the tokens it yields
   task automatic scan_byte(input logic [7:0] c, input logic eoi);
      scanned_token_type fresh[2];
      int                n;
      logic              goes_on;
      n = 0;
      if (lex_mode == LEX_NUMBER || lex_mode == LEX_IDENT) begin
         goes_on = !eoi && (lex_mode == LEX_NUMBER ? is_numeral(c)
                                                   : (is_letter(c) || is_numeral(c)));
         if (goes_on) begin
            append_run(c);
            return;
         end
         // close the open run; the ending byte is scanned again below
         fresh[n].kind   = (lex_mode == LEX_NUMBER) ? lts_pkg::KIND_NUMBER
                                                    : ident_or_keyword(run_len, run_head);
         fresh[n].length = run_len;
         fresh[n].text   = run_head;
         fresh[n].last   = 1'b0;
         n++;
         run_len  = 8'd0;
         run_head = 64'd0;
      end
      lex_mode = LEX_START;
      if (eoi) begin
         fresh[n] = '{lts_pkg::KIND_END, 8'd0, 64'd0, 1'b0};
         n++;
      end else if (is_numeral(c) || is_letter(c)) begin
         lex_mode = is_numeral(c) ? LEX_NUMBER : LEX_IDENT;
         run_len  = 8'd0;
         run_head = 64'd0;
         append_run(c);
      end else if (!is_blank(c)) begin
         fresh[n] = '{lts_pkg::KIND_CHAR, 8'd1, {56'd0, c}, 1'b0};
         n++;
      end
      if (n > 0) fresh[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens.push_back(fresh[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // sample at the rising edge: compare delivered tokens, then predict the
   // request taken at this same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("token with none owed", {53'd0, rsp_tdata[10:0]}, 64'd0);
            end else begin
               scanned_token_type want;
               want = expected_tokens.pop_front();
               if (rsp_tdata[2:0] != want.kind)
                  report_mismatch("token_kind", 64'(rsp_tdata[2:0]), 64'(want.kind));
               if (rsp_tdata[10:3] != want.length)
                  report_mismatch("token_length", 64'(rsp_tdata[10:3]), 64'(want.length));
               if (rsp_tdata[74:11] != want.text)
                  report_mismatch("text_head", rsp_tdata[74:11], want.text);
               if (rsp_tlast != want.last)
                  report_mismatch("last_of_run", 64'(rsp_tlast), 64'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tuser);
            items_accepted++;
            req_fired = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // a stretch of the run with no random idling on either side
   assign calm = items_accepted >= 600 && items_accepted < 850;

   // change inputs at the falling edge; hold a request until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         req_fired = 1'b0;
         if (source_items.size() != 0 &&
             !(source_items[0].drain_first && expected_tokens.size() != 0) &&
             (calm || $urandom_range(99) >= 11)) begin
            next_item = source_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.ch;
            req_tuser  <= next_item.eoi;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= calm || $urandom_range(99) >= 11;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_item(input logic [7:0] c, input logic eoi);
      source_items.push_back('{c, eoi, hold_next});
      hold_next = 1'b0;
      items_pushed++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] rand_letter();
      int k;
      k = $urandom_range(52);
      if (k < 26) return 8'(8'h41 + k);
      if (k < 52) return 8'(8'h61 + k - 26);
      return 8'h5f;
   endfunction

   function automatic logic [7:0] rand_blank();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? 8'h20 : 8'(8'h09 + k);
   endfunction

   initial begin
      int         pick;
      int         drain_mark;
      logic [7:0] c;

      // directed: keywords, a keyword with a tail, number ending at a letter,
      // an open run closed by end of input, both extreme bytes, every blank
      push_text("if(for\twhile");
      push_item(8'h00, 1'b1);                  // end with an identifier open
      push_text("print9 8x");
      push_item(8'h00, 1'b0);                  // zero byte is a plain char
      push_item(8'hff, 1'b0);
      push_item(8'h0b, 1'b0);
      push_item(8'h0c, 1'b0);
      push_item(8'h0a, 1'b0);
      push_item(8'h0d, 1'b0);
      push_item(8'hff, 1'b1);                  // end from start mode
      push_item(8'h37, 1'b0);                  // scanning after end restarts

      // saturating runs: first drain everything that is owed
      hold_next = 1'b1;
      push_item(8'h5f, 1'b0);
      for (int i = 0; i < 299; i++) push_item(rand_letter(), 1'b0);
      push_item(8'h2b, 1'b0);
      for (int i = 0; i < 260; i++) push_item(8'(8'h30 + $urandom_range(9)), 1'b0);
      push_item(8'h00, 1'b1);

      // random: mostly well-formed token streams, some noise
      drain_mark = items_pushed + 250;
      while (items_pushed < 1150) begin
         if (items_pushed >= drain_mark) begin
            hold_next  = 1'b1;
            drain_mark = items_pushed + 250;
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            push_text(keywords[$urandom_range(3)]);
         end else if (pick < 25) begin
            push_text(near_misses[$urandom_range(14)]);
         end else if (pick < 45) begin
            push_item(rand_letter(), 1'b0);
            repeat ($urandom_range(11)) begin
               if ($urandom_range(3) == 0) push_item(8'(8'h30 + $urandom_range(9)), 1'b0);
               else push_item(rand_letter(), 1'b0);
            end
         end else if (pick < 62) begin
            repeat ($urandom_range(12, 1)) push_item(8'(8'h30 + $urandom_range(9)), 1'b0);
         end else if (pick < 75) begin
            // any byte outside the digit, letter and blank classes
            do c = 8'($urandom_range(255));
            while (is_numeral(c) || is_letter(c) || is_blank(c));
            push_item(c, 1'b0);
         end else if (pick < 85) begin
            push_item(rand_blank(), 1'b0);
         end else if (pick < 90) begin
            push_item(8'($urandom_range(255)), 1'b1);
         end else begin
            push_item(8'($urandom_range(255)), $urandom_range(15) == 0);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every request to be taken and every token to arrive
      while (items_accepted < items_pushed || expected_tokens.size() != 0)
         @(posedge clock);
      // allow for a stray token after the last expected one
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
